>>> sv/csmb_pkg.sv
`timescale 1ns / 1ps

package csmb_pkg;

    // stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 16;

    localparam int PTR_W  = 16;
    localparam int BYTE_W = 8;
    localparam int REG_W  = 4;

    typedef enum logic [IN_TUSER_W-1:0] {
        KIND_READ  = 3'd0,
        KIND_WRITE = 3'd1,
        KIND_SOFT  = 3'd2,
        KIND_TRIG  = 3'd3,
        KIND_TICK  = 3'd4
    } t_kind;

    localparam logic [REG_W-1:0] REG_MEM    = 4'd0;
    localparam logic [REG_W-1:0] REG_IRQ    = 4'd1;
    localparam logic [REG_W-1:0] REG_PTR_LO = 4'd2;
    localparam logic [REG_W-1:0] REG_PTR_HI = 4'd3;

    // irq status byte bits
    localparam int IRQ_SET_BIT    = 7;
    localparam int IRQ_REMOTE_BIT = 1;
    localparam int IRQ_LOCAL_BIT  = 0;

    // capability area layout
    localparam logic [BYTE_W-1:0] MAGIC_A     = 8'ha3;
    localparam logic [BYTE_W-1:0] MAGIC_B     = 8'h14;
    localparam int                MAGIC_A_OFS = 5;
    localparam int                MAGIC_B_OFS = 6;
    // soft reset writes offset 4 (restart count) then offsets 0..3
    localparam logic [2:0]        SOFT_FIRST  = 3'd0;
    localparam logic [2:0]        SOFT_LAST   = 3'd4;

endpackage

>>> sv/csmb_ram.sv
`timescale 1ns / 1ps

module csmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/clockport_shared_memory_bridge.sv
`timescale 1ns / 1ps
// channel   | direction | payload
// ----------+-----------+-------------------------------------------------------
// s_axis    | in        | tdata: reg_index[3:0], write_data[11:4]; tuser: kind[2:0]
// m_axis    | out       | tdata: read_data[7:0], partner_irq_pulse[8], host_irq_assert[9]
// cfg       | in        | i_cfg_we / i_cfg_wdata: enabled
//
// one word in flight at a time; register accesses, events and memory writes go from
// ST_IDLE to ST_DONE, a memory read waits in ST_RDWAIT for the registered ram read, and
// a soft reset passes through ST_SOFT (five capability bytes written through the single ram port)
// after reset a clearing pass writes every ram entry with tready low; cfg writes are
// taken during it
// the output register frees the input side while a result waits on m_axis tready

module clockport_shared_memory_bridge #(
    parameter int MEM_ADDR_BITS = 16,
    parameter int CAP_AREA_BASE = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // reg_index [3:0], write_data [11:4], zero [15:12]
    input  logic [csmb_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // kind [2:0]
    input  logic [csmb_pkg::IN_TUSER_W-1:0]     i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // read_data [7:0], partner_irq_pulse [8], host_irq_assert [9], zero [15:10]
    output logic [csmb_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    import csmb_pkg::*;

    localparam int             AW       = MEM_ADDR_BITS;
    localparam int             DEPTH    = 1 << MEM_ADDR_BITS;
    localparam logic [AW-1:0]  CAP_ADDR = AW'(CAP_AREA_BASE);
    localparam logic [AW-1:0]  MAGIC_A_ADDR = CAP_ADDR + AW'(MAGIC_A_OFS);
    localparam logic [AW-1:0]  MAGIC_B_ADDR = CAP_ADDR + AW'(MAGIC_B_OFS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDWAIT,
        ST_SOFT,
        ST_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [AW-1:0]           r_clr_addr, n_clr_addr;
    logic [PTR_W-1:0]        r_ptr, n_ptr;
    logic [BYTE_W-1:0]       r_status, n_status;
    logic                    r_pending, n_pending;
    logic [BYTE_W-1:0]       r_restart, n_restart;
    logic [2:0]              r_step, n_step;
    logic                    r_enabled;
    logic [BYTE_W-1:0]       r_res_rd, n_res_rd;
    logic                    r_res_pulse, n_res_pulse;
    logic                    r_res_assert, n_res_assert;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data, n_out_data;

    logic                    ram_en;
    logic                    ram_we;
    logic [AW-1:0]           ram_addr;
    logic [BYTE_W-1:0]       ram_wdata;
    logic [BYTE_W-1:0]       ram_rdata;

    logic                    s_accept;
    logic [REG_W-1:0]        s_reg;
    logic [BYTE_W-1:0]       s_data;
    t_kind                   s_kind;
    logic [BYTE_W-1:0]       clear_byte;

    assign s_reg    = i_s_axis_tdata[REG_W-1:0];
    assign s_data   = i_s_axis_tdata[REG_W +: BYTE_W];
    assign s_kind   = t_kind'(i_s_axis_tuser);
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_comb begin
        if (r_clr_addr == MAGIC_A_ADDR) begin
            clear_byte = MAGIC_A;
        end else if (r_clr_addr == MAGIC_B_ADDR) begin
            clear_byte = MAGIC_B;
        end else begin
            clear_byte = '0;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_ptr        = r_ptr;
        n_status     = r_status;
        n_pending    = r_pending;
        n_restart    = r_restart;
        n_step       = r_step;
        n_res_rd     = r_res_rd;
        n_res_pulse  = r_res_pulse;
        n_res_assert = r_res_assert;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        ram_en       = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = r_ptr[AW-1:0];
        ram_wdata    = s_data;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                ram_addr   = r_clr_addr;
                ram_wdata  = clear_byte;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    n_res_rd     = '0;
                    n_res_pulse  = 1'b0;
                    n_res_assert = 1'b0;
                    n_state      = ST_DONE;
                    if (r_enabled) begin
                        case (s_kind)
                            KIND_READ: begin
                                case (s_reg)
                                    REG_MEM: begin
                                        ram_en  = 1'b1;
                                        n_ptr   = r_ptr + PTR_W'(1);
                                        n_state = ST_RDWAIT;
                                    end
                                    REG_IRQ:    n_res_rd = r_status;
                                    REG_PTR_LO: n_res_rd = r_ptr[BYTE_W-1:0];
                                    REG_PTR_HI: n_res_rd = r_ptr[PTR_W-1:BYTE_W];
                                    default: ;
                                endcase
                            end
                            KIND_WRITE: begin
                                case (s_reg)
                                    REG_MEM: begin
                                        ram_en = 1'b1;
                                        ram_we = 1'b1;
                                        n_ptr  = r_ptr + PTR_W'(1);
                                    end
                                    REG_IRQ: begin
                                        n_status    = s_data;
                                        n_res_pulse = s_data[IRQ_SET_BIT]
                                                      && s_data[IRQ_REMOTE_BIT];
                                        if (!s_data[IRQ_SET_BIT] && s_data[IRQ_LOCAL_BIT]) begin
                                            n_pending = 1'b0;
                                        end
                                    end
                                    REG_PTR_LO: n_ptr = {r_ptr[PTR_W-1:BYTE_W], s_data};
                                    REG_PTR_HI: n_ptr = {s_data, r_ptr[BYTE_W-1:0]};
                                    default: ;
                                endcase
                            end
                            KIND_SOFT: begin
                                n_restart = r_restart + BYTE_W'(1);
                                n_ptr     = '0;
                                n_status  = '0;
                                n_pending = 1'b0;
                                n_step    = SOFT_FIRST;
                                n_state   = ST_SOFT;
                            end
                            KIND_TRIG: n_pending    = 1'b1;
                            KIND_TICK: n_res_assert = r_pending;
                            default: ;
                        endcase
                    end
                end
            end
            ST_RDWAIT: begin
                n_res_rd = ram_rdata;
                n_state  = ST_DONE;
            end
            ST_SOFT: begin
                // step 0 stores the restart count at offset 4, steps 1..4 clear offsets 0..3
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = (r_step == SOFT_FIRST) ? CAP_ADDR + AW'(SOFT_LAST)
                                                   : CAP_ADDR + AW'(r_step - 3'd1);
                ram_wdata = (r_step == SOFT_FIRST) ? r_restart : '0;
                n_step    = r_step + 3'd1;
                if (r_step == SOFT_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{(OUT_TDATA_W - BYTE_W - 2){1'b0}},
                                   r_res_assert, r_res_pulse, r_res_rd};
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_ptr       <= '0;
            r_status    <= '0;
            r_pending   <= 1'b0;
            r_restart   <= '0;
            r_step      <= '0;
            r_enabled   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_ptr        <= n_ptr;
            r_status     <= n_status;
            r_pending    <= n_pending;
            r_restart    <= n_restart;
            r_step       <= n_step;
            r_out_valid  <= n_out_valid;
            r_res_rd     <= n_res_rd;
            r_res_pulse  <= n_res_pulse;
            r_res_assert <= n_res_assert;
            r_out_data   <= n_out_data;
            if (i_cfg_we) begin
                r_enabled <= i_cfg_wdata;
            end
        end
    end

    csmb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // no word taken while the clearing pass runs
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_s_axis_tready)
        else $error("input accepted during clearing pass");

    // read wait only follows a ram read issue
    a_rdwait_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RDWAIT) |-> $past(ram_en && !ram_we))
        else $error("read wait without ram read");

    // capability writes use step 0..4 only
    a_soft_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SOFT) |-> (r_step <= SOFT_LAST))
        else $error("soft reset step out of range");

    // pointer and pending flag stay clear while capability bytes are written
    a_soft_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SOFT) |-> (r_ptr == '0 && !r_pending && r_status == '0))
        else $error("soft reset state not cleared");

    // a result is only loaded when the output register is free or draining
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !i_m_axis_tready) |=> (r_state == ST_DONE))
        else $error("pending result lost");

endmodule
